/* sv/aip_pkg.sv */
// ----------------------------------------------------------------------------
// aip_pkg: shared types and constants for the ascii integer parser
// Transaction payload structs, parse phase codes, character constants and
// the digit decode function.
// ----------------------------------------------------------------------------
package aip_pkg;

  // input transaction: one character plus conversion options
  typedef struct packed {
    logic [7:0] char_in;
    logic       begin_req;
    logic [4:0] base_select;
    logic       allow_minus;
  } parser_in_t;

  // output transaction: one finished conversion
  typedef struct packed {
    logic [63:0] value;
    logic [7:0]  consumed_count;
  } parser_out_t;

  // parse phase codes
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_START  = 3'd1,
    PH_AUTO0  = 3'd2,
    PH_AUTOX  = 3'd3,
    PH_HEX0   = 3'd4,
    PH_DIGITS = 3'd5
  } phase_t;

  // character codes
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_MINUS   = 8'h2d;

  // bases
  localparam logic [4:0] BASE_AUTO = 5'd0;
  localparam logic [4:0] BASE_OCT  = 5'd8;
  localparam logic [4:0] BASE_DEC  = 5'd10;
  localparam logic [4:0] BASE_HEX  = 5'd16;

  // digit value marking a character that is no digit at all
  localparam logic [4:0] NOT_DIGIT = 5'd16;

  // digit value of a character, NOT_DIGIT when it is no hex digit
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        d = c - CH_ZERO;
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
        d = c - CH_UPPER_A + 8'd10;
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
        d = c - CH_LOWER_A + 8'd10;
      end else begin
        d = {3'b000, NOT_DIGIT};
      end
      digit_of = d[4:0];
    end
  endfunction

endpackage

/* sv/ascii_integer_parser.sv */
// ----------------------------------------------------------------------------
// ascii_integer_parser: streaming integer parser with base detection
// Takes one character per input transaction and builds an integer in the
// manner of strtoul. A transaction with begin_req opens a conversion and
// supplies the base (0 auto-detects octal or hex from a 0 / 0x prefix) and
// whether a leading minus is allowed. The first non-digit closes the
// conversion and produces one output transaction with the value (two's
// complement when negated) and the consumed character count; that closing
// character is not consumed. One character is taken every cycle unless the
// skid entry is full: each character runs through a single 64x5 multiply-add
// and the phase logic in the cycle it is accepted, so throughput is one
// transaction per clock; a result is registered into the output register.
// A two-entry output buffer keeps input flowing while a result waits.
// ----------------------------------------------------------------------------
module ascii_integer_parser #(
  parameter int MAX_COUNT = 255
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  aip_pkg::parser_in_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output aip_pkg::parser_out_t out_data
);

  localparam int CW = $clog2(MAX_COUNT + 1);
  localparam int XW = (CW > 8) ? CW : 8;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_COUNT);

  // parse state
  aip_pkg::phase_t phase, phase_next;
  logic [63:0]     acc, acc_next;
  logic [4:0]      base, base_next;
  logic            neg, neg_next;
  logic [CW-1:0]   cnt, cnt_next;

  // output buffer
  aip_pkg::parser_out_t skid_data;
  logic                 skid_valid;

  // step working values
  aip_pkg::phase_t      ph_s;
  logic [63:0]          acc_s;
  logic [4:0]           base_s;
  logic                 neg_s;
  logic [CW-1:0]        cnt_s;
  logic [CW-1:0]        cnt_a;
  logic [XW-1:0]        cnt_x;
  logic [4:0]           step_base;
  logic [4:0]           dig;
  logic                 is_x;
  logic                 cnt_inc;
  logic                 do_digit;
  logic                 do_finish;
  logic                 digit_ok;
  logic [63:0]          prod;
  logic                 res_valid;
  aip_pkg::parser_out_t res_data;

  logic in_fire;
  logic out_fire;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // character classification
  assign dig  = aip_pkg::digit_of(in_data.char_in);
  assign is_x = (in_data.char_in == aip_pkg::CH_UPPER_X) ||
                (in_data.char_in == aip_pkg::CH_LOWER_X);

  // one parse step: phase decisions, multiply-add, result
  always_comb begin
    if (in_data.begin_req) begin
      ph_s   = aip_pkg::PH_START;
      acc_s  = 64'd0;
      base_s = in_data.base_select;
      neg_s  = 1'b0;
      cnt_s  = '0;
    end else begin
      ph_s   = phase;
      acc_s  = acc;
      base_s = base;
      neg_s  = neg;
      cnt_s  = cnt;
    end

    phase_next = ph_s;
    base_next  = base_s;
    neg_next   = neg_s;
    acc_next   = acc_s;
    step_base  = base_s;
    cnt_inc    = 1'b0;
    do_digit   = 1'b0;
    do_finish  = 1'b0;

    if (in_data.begin_req && in_data.allow_minus &&
        in_data.char_in == aip_pkg::CH_MINUS) begin
      neg_next = 1'b1;
      cnt_inc  = 1'b1;
    end else begin
      case (ph_s)
        aip_pkg::PH_START: begin
          if (base_s == aip_pkg::BASE_AUTO) begin
            if (in_data.char_in == aip_pkg::CH_ZERO) begin
              base_next  = aip_pkg::BASE_OCT;
              cnt_inc    = 1'b1;
              phase_next = aip_pkg::PH_AUTO0;
            end else begin
              base_next = aip_pkg::BASE_DEC;
              step_base = aip_pkg::BASE_DEC;
              do_digit  = 1'b1;
            end
          end else if (base_s == aip_pkg::BASE_HEX &&
                       in_data.char_in == aip_pkg::CH_ZERO) begin
            cnt_inc    = 1'b1;
            phase_next = aip_pkg::PH_HEX0;
          end else begin
            do_digit = 1'b1;
          end
        end
        aip_pkg::PH_AUTO0: begin
          if (is_x) begin
            phase_next = aip_pkg::PH_AUTOX;
          end else begin
            do_digit = 1'b1;
          end
        end
        aip_pkg::PH_AUTOX: begin
          // x is taken only when a hex digit follows it
          if (dig < aip_pkg::NOT_DIGIT) begin
            base_next = aip_pkg::BASE_HEX;
            step_base = aip_pkg::BASE_HEX;
            cnt_inc   = 1'b1;
            do_digit  = 1'b1;
          end else begin
            do_finish = 1'b1;
          end
        end
        aip_pkg::PH_HEX0: begin
          if (is_x) begin
            cnt_inc    = 1'b1;
            phase_next = aip_pkg::PH_DIGITS;
          end else begin
            do_digit = 1'b1;
          end
        end
        aip_pkg::PH_DIGITS: begin
          do_digit = 1'b1;
        end
        default: begin
          phase_next = aip_pkg::PH_IDLE;
        end
      endcase
    end

    // saturating count for a prefix character
    cnt_a = (cnt_inc && cnt_s < CNT_MAX) ? cnt_s + CW'(1) : cnt_s;
    cnt_next = cnt_a;

    // digit accumulate modulo 2^64
    prod     = acc_s * 64'(step_base);
    digit_ok = dig < step_base;
    if (do_digit) begin
      phase_next = aip_pkg::PH_DIGITS;
      if (digit_ok) begin
        acc_next = prod + 64'(dig);
        cnt_next = (cnt_a < CNT_MAX) ? cnt_a + CW'(1) : cnt_a;
      end else begin
        do_finish = 1'b1;
      end
    end

    // close conversion
    res_valid = do_finish;
    if (do_finish) begin
      phase_next = aip_pkg::PH_IDLE;
    end
    cnt_x                   = XW'(cnt_a);
    res_data.value          = neg_s ? (64'd0 - acc_s) : acc_s;
    res_data.consumed_count = (cnt_x > XW'(255)) ? 8'hff : cnt_x[7:0];
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= aip_pkg::PH_IDLE;
      acc   <= 64'd0;
      base  <= aip_pkg::BASE_DEC;
      neg   <= 1'b0;
      cnt   <= '0;
    end else if (in_fire) begin
      phase <= phase_next;
      acc   <= acc_next;
      base  <= base_next;
      neg   <= neg_next;
      cnt   <= cnt_next;
    end
  end

  // output register with skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (in_fire && res_valid) begin
      if (!out_valid || out_ready) begin
        out_data  <= res_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= res_data;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a result while output register is empty");

  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !in_data.begin_req && phase == aip_pkg::PH_IDLE) |-> !res_valid)
    else $error("result produced with no open conversion");

  a_result_closes: assert property (@(posedge clk) disable iff (rst)
    (in_fire && res_valid) |=> (phase == aip_pkg::PH_IDLE))
    else $error("conversion still open after its result");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_MAX)
    else $error("character count beyond its limit");

  a_autox_octal: assert property (@(posedge clk) disable iff (rst)
    (phase == aip_pkg::PH_AUTOX) |-> (base == aip_pkg::BASE_OCT && acc == 64'd0))
    else $error("x prefix pending without a lone octal zero");

endmodule
